[design/bit_packed_record_decoder_macros.svh]
// ----------------------------------------------------------------------------
// bit_packed_record_decoder_macros.svh
// assertion helpers used by the record decoder datapath
// ----------------------------------------------------------------------------
`ifndef BIT_PACKED_RECORD_DECODER_MACROS_SVH
`define BIT_PACKED_RECORD_DECODER_MACROS_SVH

// same-cycle implication, held off during reset
`define BPR_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BPR_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/bpr_pkg.sv]
// ----------------------------------------------------------------------------
// bpr_pkg
// types, constants and helper functions of the bit-packed record decoder
// ----------------------------------------------------------------------------
`default_nettype none

package bpr_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int VALUE_W = 31;
    localparam int ID_W    = 3;
    localparam int FW_W    = 5;
    localparam int CNT_W   = 4;

    // bits in the width field of each record kind, and color transform flag bits
    localparam int RECT_WIDTH_BITS = 5;
    localparam int CX_WIDTH_BITS   = 4;
    localparam int CX_FLAG_BITS    = 2;

    typedef logic [BYTE_W-1:0]         byte_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [ID_W-1:0]           id_t;
    typedef logic [FW_W-1:0]           fw_t;
    typedef logic [CNT_W-1:0]          cnt_t;
    typedef logic [1:0]                kind_t;

    // record kinds
    localparam kind_t KIND_RECT     = 2'd0;
    localparam kind_t KIND_MATRIX   = 2'd1;
    localparam kind_t KIND_CX       = 2'd2;
    localparam kind_t KIND_CX_ALPHA = 2'd3;

    // field ids of interest
    localparam id_t  ID_RECT_LAST = 3'd3;
    localparam id_t  ID_MX_SKEW   = 3'd2;
    localparam id_t  ID_MX_TRANS  = 3'd4;
    localparam logic [ID_W:0] ID_MX_COUNT = 4'd6;
    localparam logic [ID_W:0] ID_NONE     = 4'd8;

    localparam cnt_t CNT_FULL = 4'd8;

    // controller commands to the datapath
    typedef struct packed {
        logic load;
        logic take_bit;
        logic emit;
        logic done;
    } cmd_t;

    // datapath status to the controller
    typedef struct packed {
        logic need_emit;
        logic need_bit;
        logic pend_busy;
        logic out_free;
    } status_t;

    // color transform term present for this id
    function automatic logic cx_enabled(input id_t id, input logic [1:0] flags,
                                        input logic alpha);
        logic ok;
        ok = !((id[1:0] == 2'd3) && !alpha);
        return ok && (id[2] ? flags[1] : flags[0]);
    endfunction

    // first enabled color transform id at or after from, ID_NONE if none
    function automatic logic [ID_W:0] cx_next(input logic [ID_W:0] from,
                                              input logic [1:0] flags,
                                              input logic alpha);
        logic [ID_W:0] r;
        r = ID_NONE;
        for (int i = 7; i >= 0; i--) begin
            if ((4'(i) >= from) && cx_enabled(3'(i), flags, alpha))
            begin
                r = 4'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[design/bpr_stream_if.sv]
// ----------------------------------------------------------------------------
// bpr_stream_if
// byte stream channel into the record decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface bpr_stream_if;
    import bpr_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

[design/bpr_result_if.sv]
// ----------------------------------------------------------------------------
// bpr_result_if
// decoded field channel out of the record decoder
// ----------------------------------------------------------------------------
`default_nettype none

interface bpr_result_if;
    import bpr_pkg::*;

    logic   valid;
    logic   ready;
    id_t    field_id;
    value_t field_value;
    logic   has_value;
    logic   record_end;
    logic   run_last;

    modport source (output valid, output field_id, output field_value,
                    output has_value, output record_end, output run_last,
                    input ready);
    modport sink   (input valid, input field_id, input field_value,
                    input has_value, input record_end, input run_last,
                    output ready);
endinterface

`default_nettype wire

[design/bpr_cfg_if.sv]
// ----------------------------------------------------------------------------
// bpr_cfg_if
// configuration write channel for the record kind register
// ----------------------------------------------------------------------------
`default_nettype none

interface bpr_cfg_if;
    import bpr_pkg::*;

    logic  valid;
    logic  ready;
    kind_t record_kind;

    modport source (output valid, output record_kind, input ready);
    modport sink   (input valid, input record_kind, output ready);
endinterface

`default_nettype wire

[design/bpr_ctrl.sv]
// ----------------------------------------------------------------------------
// bpr_ctrl
// sequencer: takes a byte, steps its bits and results, then releases it
// ----------------------------------------------------------------------------
`default_nettype none

module bpr_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bpr_pkg::status_t status,
    output bpr_pkg::cmd_t        cmd
);
    import bpr_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    // one micro-op per cycle unless both result slots are full; results first, then bits, then release
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && ready_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_RUN;
                    ready_next = 1'b0;
                end
            end
            S_RUN:
            begin
                if (status.need_emit)
                begin
                    cmd.emit = !status.pend_busy || status.out_free;
                end
                else if (status.need_bit)
                begin
                    cmd.take_bit = 1'b1;
                end
                else if (!status.pend_busy || status.out_free)
                begin
                    cmd.done   = 1'b1;
                    state_next = S_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign in_ready = ready_reg;

endmodule

`default_nettype wire

[design/bpr_datapath.sv]
// ----------------------------------------------------------------------------
// bpr_datapath
// record state, bit parser, sign extension and result staging
// ----------------------------------------------------------------------------
`default_nettype none
`include "bit_packed_record_decoder_macros.svh"

module bpr_datapath (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire bpr_pkg::byte_t   data_byte,
    input  wire bpr_pkg::cmd_t    cmd,
    output bpr_pkg::status_t      status,
    bpr_cfg_if.sink               cfg,
    bpr_result_if.source          result
);
    import bpr_pkg::*;

    typedef enum logic [2:0] {
        ST_START,
        ST_MFLAG,
        ST_CFLAGS,
        ST_WIDTH,
        ST_VALUES,
        ST_END,
        ST_EMPTY
    } stage_t;

    // record state
    kind_t            kind_reg, kind_next;
    stage_t           stage_reg, stage_next;
    fw_t              fw_reg, fw_next;
    logic [1:0]       flags_reg, flags_next;
    id_t              fi_reg, fi_next;
    logic [VALUE_W-1:0] acc_reg, acc_next;
    fw_t              gath_reg, gath_next;
    byte_t            sh_reg, sh_next;
    cnt_t             cnt_reg, cnt_next;

    // pending and output result slots
    logic   pend_valid_reg;
    id_t    pend_id_reg;
    value_t pend_val_reg;
    logic   pend_has_reg;
    logic   pend_end_reg;
    logic   out_valid_reg;
    id_t    out_id_reg;
    value_t out_val_reg;
    logic   out_has_reg;
    logic   out_end_reg;
    logic   out_last_reg;

    // working values of the parser step
    stage_t             st_v;
    id_t                fi_v;
    logic [1:0]         flg_v;
    logic [VALUE_W-1:0] acc_v;
    fw_t                g_v;
    fw_t                fw_v;
    fw_t                width_bits;
    logic [ID_W:0]      nx_v;
    logic               bit_in;
    logic               alpha;

    // emitted result
    id_t                em_id;
    value_t             em_val;
    logic               em_has;
    logic               em_end;
    logic [VALUE_W-1:0] upper;
    logic               sign_bit;

    logic cfg_fire;
    logic out_fire;
    logic out_free;

    assign cfg.ready = 1'b1;
    assign cfg_fire  = cfg.valid;
    assign out_fire  = out_valid_reg && result.ready;
    assign out_free  = !out_valid_reg || result.ready;
    assign bit_in    = sh_reg[BYTE_W-1];
    assign alpha     = (kind_reg == KIND_CX_ALPHA);
    assign width_bits = kind_reg[1] ? FW_W'(CX_WIDTH_BITS) : FW_W'(RECT_WIDTH_BITS);

    // sign extension of the gathered field
    assign upper    = {VALUE_W{1'b1}} << fw_reg;
    assign sign_bit = acc_reg[fw_reg - 5'd1];

    // status to the controller
    always_comb
    begin
        status.need_emit = ((stage_reg == ST_VALUES) && (gath_reg == fw_reg))
                           || (stage_reg == ST_EMPTY);
        status.need_bit  = (cnt_reg != '0) && (stage_reg != ST_END);
        status.pend_busy = pend_valid_reg;
        status.out_free  = out_free;
    end

    // next record state
    always_comb
    begin
        kind_next  = kind_reg;
        stage_next = stage_reg;
        fw_next    = fw_reg;
        flags_next = flags_reg;
        fi_next    = fi_reg;
        acc_next   = acc_reg;
        gath_next  = gath_reg;
        sh_next    = sh_reg;
        cnt_next   = cnt_reg;
        st_v   = stage_reg;
        fi_v   = fi_reg;
        flg_v  = flags_reg;
        acc_v  = acc_reg;
        g_v    = gath_reg;
        fw_v   = fw_reg;
        nx_v   = ID_NONE;
        em_id  = fi_reg;
        em_val = '0;
        em_has = 1'b1;
        em_end = 1'b0;

        if (cfg_fire)
        begin
            kind_next  = cfg.record_kind;
            stage_next = ST_START;
            fw_next    = '0;
            flags_next = '0;
            fi_next    = '0;
            acc_next   = '0;
            gath_next  = '0;
        end
        else if (cmd.load)
        begin
            sh_next  = data_byte;
            cnt_next = CNT_FULL;
        end
        else if (cmd.take_bit)
        begin
            sh_next  = {sh_reg[BYTE_W-2:0], 1'b0};
            cnt_next = cnt_reg - 4'd1;
            // a new record begins with this bit
            if (st_v == ST_START)
            begin
                fi_v  = '0;
                flg_v = '0;
                acc_v = '0;
                g_v   = '0;
                if (kind_reg == KIND_RECT)
                begin
                    st_v = ST_WIDTH;
                end
                else if (kind_reg == KIND_MATRIX)
                begin
                    st_v = ST_MFLAG;
                end
                else
                begin
                    st_v = ST_CFLAGS;
                end
            end
            unique case (st_v)
                ST_MFLAG:
                begin
                    if (bit_in)
                    begin
                        st_v  = ST_WIDTH;
                        acc_v = '0;
                        g_v   = '0;
                    end
                    else if (fi_v >= ID_MX_SKEW)
                    begin
                        fi_v  = ID_MX_TRANS;
                        st_v  = ST_WIDTH;
                        acc_v = '0;
                        g_v   = '0;
                    end
                    else
                    begin
                        fi_v = fi_v + 3'd2;
                    end
                end
                ST_CFLAGS:
                begin
                    flg_v = {flg_v[0], bit_in};
                    g_v   = g_v + 5'd1;
                    if (g_v >= FW_W'(CX_FLAG_BITS))
                    begin
                        st_v  = ST_WIDTH;
                        acc_v = '0;
                        g_v   = '0;
                    end
                end
                ST_WIDTH:
                begin
                    acc_v = {{(VALUE_W-5){1'b0}}, acc_v[3:0], bit_in};
                    g_v   = g_v + 5'd1;
                    if (g_v >= width_bits)
                    begin
                        fw_v  = acc_v[FW_W-1:0];
                        acc_v = '0;
                        g_v   = '0;
                        st_v  = ST_VALUES;
                        if (kind_reg[1])
                        begin
                            nx_v = cx_next('0, flg_v, alpha);
                            if (nx_v[ID_W])
                            begin
                                st_v = ST_EMPTY;
                            end
                            else
                            begin
                                fi_v = nx_v[ID_W-1:0];
                            end
                        end
                    end
                end
                ST_VALUES:
                begin
                    acc_v = {acc_v[VALUE_W-2:0], bit_in};
                    g_v   = g_v + 5'd1;
                end
                default:
                begin
                end
            endcase
            stage_next = st_v;
            fi_next    = fi_v;
            flags_next = flg_v;
            acc_next   = acc_v;
            gath_next  = g_v;
            fw_next    = fw_v;
        end
        else if (cmd.emit)
        begin
            acc_next  = '0;
            gath_next = '0;
            if (stage_reg == ST_EMPTY)
            begin
                // color transform with neither term
                em_id      = '0;
                em_has     = 1'b0;
                em_end     = 1'b1;
                stage_next = ST_END;
            end
            else
            begin
                if (fw_reg == '0)
                begin
                    em_val = '0;
                end
                else if (sign_bit)
                begin
                    em_val = value_t'(acc_reg | upper);
                end
                else
                begin
                    em_val = value_t'(acc_reg);
                end
                if (kind_reg == KIND_RECT)
                begin
                    if (fi_reg >= ID_RECT_LAST)
                    begin
                        em_end = 1'b1;
                    end
                    else
                    begin
                        fi_next = fi_reg + 3'd1;
                    end
                end
                else if (kind_reg == KIND_MATRIX)
                begin
                    nx_v = {1'b0, fi_reg} + 4'd1;
                    if (nx_v >= ID_MX_COUNT)
                    begin
                        em_end = 1'b1;
                    end
                    else
                    begin
                        fi_next = nx_v[ID_W-1:0];
                        if (nx_v[ID_W-1:0] == ID_MX_SKEW)
                        begin
                            stage_next = ST_MFLAG;
                        end
                        else if (nx_v[ID_W-1:0] == ID_MX_TRANS)
                        begin
                            stage_next = ST_WIDTH;
                        end
                    end
                end
                else
                begin
                    nx_v = cx_next({1'b0, fi_reg} + 4'd1, flags_reg, alpha);
                    if (nx_v[ID_W])
                    begin
                        em_end = 1'b1;
                    end
                    else
                    begin
                        fi_next = nx_v[ID_W-1:0];
                    end
                end
                if (em_end)
                begin
                    stage_next = ST_END;
                end
            end
        end
        else if (cmd.done)
        begin
            // trailing bits dropped, next byte opens a record
            if (stage_reg == ST_END)
            begin
                stage_next = ST_START;
                fw_next    = '0;
                flags_next = '0;
                fi_next    = '0;
                acc_next   = '0;
                gath_next  = '0;
            end
        end
    end

    // record state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_MATRIX;
            stage_reg <= ST_START;
            fw_reg    <= '0;
            flags_reg <= '0;
            fi_reg    <= '0;
            acc_reg   <= '0;
            gath_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            stage_reg <= stage_next;
            fw_reg    <= fw_next;
            flags_reg <= flags_next;
            fi_reg    <= fi_next;
            acc_reg   <= acc_next;
            gath_reg  <= gath_next;
            cnt_reg   <= cnt_next;
        end
    end

    // byte shift register
    always_ff @(posedge clk)
    begin
        sh_reg <= sh_next;
    end

    // slot valid flags; the output slot refills from the pending slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= cmd.emit || (pend_valid_reg && !cmd.done);
            out_valid_reg  <= (out_valid_reg && !out_fire)
                              || ((cmd.emit || cmd.done) && pend_valid_reg);
        end
    end

    // slot payloads; the held result leaves with run_last on release
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            pend_id_reg  <= em_id;
            pend_val_reg <= em_val;
            pend_has_reg <= em_has;
            pend_end_reg <= em_end;
        end
        if ((cmd.emit || cmd.done) && pend_valid_reg)
        begin
            out_id_reg   <= pend_id_reg;
            out_val_reg  <= pend_val_reg;
            out_has_reg  <= pend_has_reg;
            out_end_reg  <= pend_end_reg;
            out_last_reg <= cmd.done;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.field_id    = out_id_reg;
    assign result.field_value = out_val_reg;
    assign result.has_value   = out_has_reg;
    assign result.record_end  = out_end_reg;
    assign result.run_last    = out_last_reg;

    // checks
    `BPR_ASSERT_NOW(a_emit_room, clk, rst_n, cmd.emit && pend_valid_reg, out_free, "result emitted with both slots full")
    `BPR_ASSERT_NOW(a_end_is_last, clk, rst_n, out_valid_reg && out_end_reg, out_last_reg, "record end not last of its byte")
    `BPR_ASSERT_NOW(a_empty_ends, clk, rst_n, out_valid_reg && !out_has_reg, out_end_reg && (out_val_reg == '0), "empty result not a record end")
    `BPR_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_fire, stage_reg == ST_START, "kind write did not restart the record")

endmodule

`default_nettype wire

[design/bit_packed_record_decoder.sv]
// ----------------------------------------------------------------------------
// bit_packed_record_decoder
// decodes msb-first bit-packed rectangle, matrix and color transform records
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | payload
//   ---------+-----+---------------+------------------------------------------
//   stream   | in  | valid / ready | data_byte[7:0]
//   result   | out | valid / ready | field_id, field_value, has_value,
//            |     |               | record_end, run_last
//   cfg      | in  | valid / ready | record_kind[1:0] (always ready)
//
//   each byte is loaded, its bits pass the serial parser, every result it
//   completes is emitted, and the byte is released before the next is taken;
//   a record that ends early skips its remaining bits
//   results pass a pending slot and an output register; a stalled output
//   holds the sequencer only when both slots are full
//   reset: record kind matrix, decoder waits for the start of a record
//
`default_nettype none

module bit_packed_record_decoder (
    input  wire logic    clk,
    input  wire logic    rst_n,
    bpr_stream_if.sink   stream,
    bpr_result_if.source result,
    bpr_cfg_if.sink      cfg
);
    import bpr_pkg::*;

    cmd_t    cmd;
    status_t status;
    logic    in_ready;

    assign stream.ready = in_ready;

    // sequencer
    bpr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stream.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // parser and result staging
    bpr_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (stream.data_byte),
        .cmd       (cmd),
        .status    (status),
        .cfg       (cfg),
        .result    (result)
    );

endmodule

`default_nettype wire

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// checks the bit-packed record decoder against a cycle-free predictor; byte
// stream and result channel run with random gaps and stalls, the record kind
// is changed between drained phases, and every decoded field is compared
// ----------------------------------------------------------------------------

module testbench;
    import bpr_pkg::*;

    localparam int  HALF_PERIOD      = 6;
    localparam int  RESET_CYCLES     = 5;
    localparam int  SETTLE_CYCLES    = 40;
    localparam int  LONG_HOLD_CYCLES = 300;
    localparam int  PHASE_BYTES      = 22;
    localparam int  TIMEOUT_NS       = 2000000;

    // field ids and counts the predictor walks through
    localparam id_t        RECT_LAST_ID  = 3'd3;
    localparam id_t        MX_TRANS_ID   = 3'd4;
    localparam id_t        MX_FIELDS     = 3'd6;
    localparam logic [3:0] CX_NONE       = 4'd8;
    localparam int         MX_WIDTH_BITS = RECT_WIDTH_BITS;
    localparam int         FLAG_MUL      = 0;
    localparam int         FLAG_ADD      = 1;

    typedef enum logic [2:0] {
        PS_START,
        PS_MFLAG,
        PS_CFLAGS,
        PS_WIDTH,
        PS_VALUES,
        PS_END
    } parse_stage_t;

    typedef struct packed {
        id_t    field_id;
        value_t field_value;
        logic   has_value;
        logic   record_end;
        logic   run_last;
    } field_result_t;

    logic clk;
    logic rst_n;

    bpr_stream_if stream_ch ();
    bpr_result_if result_ch ();
    bpr_cfg_if    cfg_ch ();

    bit_packed_record_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_ch.sink),
        .result (result_ch.source),
        .cfg    (cfg_ch.sink)
    );

    // decoder state as predicted
    kind_t              pk_kind;
    parse_stage_t       pk_stage;
    fw_t                pk_width;
    logic [1:0]         pk_flags;
    id_t                pk_index;
    logic [VALUE_W-1:0] pk_acc;
    logic [4:0]         pk_count;

    field_result_t byte_fields[$];
    field_result_t expected_fields[$];

    // stimulus bookkeeping
    byte_t send_bytes[$];
    logic  bit_buf[$];
    int    bytes_queued    = 0;
    int    bytes_accepted  = 0;
    int    fields_checked  = 0;
    int    empty_records   = 0;
    int    kind_writes     = 0;
    int    mismatch_count  = 0;

    // handshake seen at the last rising edge
    logic in_fire  = 1'b0;
    logic out_fire = 1'b0;

    // pacing controls set by the stimulus sequence
    logic sender_steady   = 1'b0;
    logic receiver_steady = 1'b0;
    int   long_hold_token = 0;
    int   hold_token_seen = 0;
    int   long_stall      = 0;
    int   stall_left      = 0;
    int   gap_left        = 0;

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic void clear_record_state();
        pk_stage = PS_START;
        pk_width = '0;
        pk_flags = '0;
        pk_index = '0;
        pk_acc   = '0;
        pk_count = '0;
    endfunction

    function automatic logic term_present(logic [3:0] id);
        if (id[1:0] == 2'd3 && pk_kind != KIND_CX_ALPHA)
            return 1'b0;
        return (id < 4'd4) ? pk_flags[FLAG_MUL] : pk_flags[FLAG_ADD];
    endfunction

    function automatic logic [3:0] next_term(logic [3:0] from);
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) >= from && term_present(4'(i)))
                return 4'(i);
        end
        return CX_NONE;
    endfunction

    function automatic void push_field(id_t id, value_t val, logic has);
        field_result_t f;
        f.field_id    = id;
        f.field_value = val;
        f.has_value   = has;
        f.record_end  = 1'b0;
        f.run_last    = 1'b0;
        byte_fields.push_back(f);
    endfunction

    function automatic void close_record();
        field_result_t f;
        if (byte_fields.size() > 0)
        begin
            f = byte_fields[byte_fields.size()-1];
            f.record_end = 1'b1;
            byte_fields[byte_fields.size()-1] = f;
        end
        pk_stage = PS_END;
    endfunction

    // sign extension from the current field width
    function automatic value_t extend_field();
        logic [VALUE_W-1:0] shifted;
        int                 sh;
        if (pk_width == '0)
            return '0;
        sh      = VALUE_W - int'(pk_width);
        shifted = pk_acc << sh;
        return value_t'($signed(shifted) >>> sh);
    endfunction

    function automatic void begin_width();
        pk_stage = PS_WIDTH;
        pk_acc   = '0;
        pk_count = '0;
    endfunction

    // emit every field whose bits are complete, zero-width ones included
    function automatic void drain_fields();
        id_t        id;
        logic [3:0] nx;
        while (pk_stage == PS_VALUES && pk_count == pk_width)
        begin
            id = pk_index;
            push_field(id, extend_field(), 1'b1);
            pk_acc   = '0;
            pk_count = '0;
            if (pk_kind == KIND_RECT)
            begin
                if (id >= RECT_LAST_ID)
                    close_record();
                else
                    pk_index = id + 3'd1;
            end
            else if (pk_kind == KIND_MATRIX)
            begin
                pk_index = id + 3'd1;
                if (pk_index >= MX_FIELDS)
                    close_record();
                else if (pk_index == 3'd2)
                    pk_stage = PS_MFLAG;
                else if (pk_index == MX_TRANS_ID)
                    begin_width();
            end
            else
            begin
                nx = next_term({1'b0, id} + 4'd1);
                if (nx >= CX_NONE)
                    close_record();
                else
                    pk_index = nx[2:0];
            end
        end
    endfunction

    function automatic void finish_width();
        logic [3:0] first;
        pk_width = pk_acc[FW_W-1:0];
        pk_acc   = '0;
        pk_count = '0;
        if (pk_kind >= KIND_CX)
        begin
            first = next_term(4'd0);
            // color transform with neither term set
            if (first >= CX_NONE)
            begin
                push_field(3'd0, '0, 1'b0);
                close_record();
                return;
            end
            pk_index = first[2:0];
        end
        pk_stage = PS_VALUES;
        drain_fields();
    endfunction

    function automatic void take_bit(logic b);
        if (pk_stage == PS_START)
        begin
            pk_index = '0;
            pk_flags = '0;
            pk_acc   = '0;
            pk_count = '0;
            if (pk_kind == KIND_RECT)
                pk_stage = PS_WIDTH;
            else if (pk_kind == KIND_MATRIX)
                pk_stage = PS_MFLAG;
            else
                pk_stage = PS_CFLAGS;
        end
        case (pk_stage)
            PS_MFLAG:
            begin
                if (b)
                    begin_width();
                else
                begin
                    pk_index = pk_index + 3'd2;
                    if (pk_index >= MX_TRANS_ID)
                    begin
                        pk_index = MX_TRANS_ID;
                        begin_width();
                    end
                end
            end
            PS_CFLAGS:
            begin
                pk_flags = {pk_flags[0], b};
                pk_count = pk_count + 5'd1;
                if (pk_count >= 5'(CX_FLAG_BITS))
                    begin_width();
            end
            PS_WIDTH:
            begin
                pk_acc   = {26'd0, pk_acc[3:0], b};
                pk_count = pk_count + 5'd1;
                if (pk_count >= ((pk_kind >= KIND_CX) ? 5'(CX_WIDTH_BITS)
                                                       : 5'(RECT_WIDTH_BITS)))
                    finish_width();
            end
            PS_VALUES:
            begin
                pk_acc   = {pk_acc[VALUE_W-2:0], b};
                pk_count = pk_count + 5'd1;
                drain_fields();
            end
            default: ;
        endcase
    endfunction

    // expected results of one accepted byte, msb first
    function automatic void decode_byte(byte_t data);
        field_result_t f;
        byte_fields.delete();
        for (int i = 7; i >= 0; i--)
        begin
            if (pk_stage == PS_END)
                break;
            take_bit(data[i]);
        end
        if (pk_stage == PS_END)
            clear_record_state();
        if (byte_fields.size() > 0)
        begin
            f = byte_fields[byte_fields.size()-1];
            f.run_last = 1'b1;
            byte_fields[byte_fields.size()-1] = f;
        end
        foreach (byte_fields[i])
            expected_fields.push_back(byte_fields[i]);
    endfunction

    function automatic void report_field(string name, logic signed [31:0] exp_v,
                                         logic signed [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
            mismatch_count++;
        end
    endfunction

    // ------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------

    always
    begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    initial
    begin
        clk                   = 1'b0;
        rst_n                 = 1'b0;
        stream_ch.valid       = 1'b0;
        stream_ch.data_byte   = '0;
        result_ch.ready       = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.record_kind    = KIND_RECT;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------
    // monitor: config, byte and result transactions at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : monitor
        field_result_t exp_f;
        in_fire  <= rst_n && stream_ch.valid && stream_ch.ready;
        out_fire <= rst_n && result_ch.valid && result_ch.ready;
        if (!rst_n)
        begin
            pk_kind = KIND_MATRIX;
            clear_record_state();
        end
        else
        begin
            // kind write aborts the record in progress
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                pk_kind = cfg_ch.record_kind;
                clear_record_state();
                kind_writes++;
            end
            if (stream_ch.valid && stream_ch.ready)
            begin
                decode_byte(stream_ch.data_byte);
                bytes_accepted++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_fields.size() == 0)
                begin
                    $error("unexpected result: field_id %0d field_value %0d",
                           result_ch.field_id, result_ch.field_value);
                    mismatch_count++;
                end
                else
                begin
                    exp_f = expected_fields.pop_front();
                    report_field("field_id", 32'(exp_f.field_id),
                                 32'(result_ch.field_id));
                    report_field("field_value", 32'(exp_f.field_value),
                                 32'(result_ch.field_value));
                    report_field("has_value", 32'(exp_f.has_value),
                                 32'(result_ch.has_value));
                    report_field("record_end", 32'(exp_f.record_end),
                                 32'(result_ch.record_end));
                    report_field("run_last", 32'(exp_f.run_last),
                                 32'(result_ch.run_last));
                    fields_checked++;
                    if (!exp_f.has_value)
                        empty_records++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: byte stream, changes at the falling edge
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stream_ch.valid && !in_fire)
            begin
                // hold the byte until it is taken
            end
            else if (gap_left > 0)
            begin
                stream_ch.valid <= 1'b0;
                gap_left        <= gap_left - 1;
            end
            else if (send_bytes.size() > 0)
            begin
                stream_ch.valid     <= 1'b1;
                stream_ch.data_byte <= send_bytes.pop_front();
                gap_left            <= sender_steady ? 0 : $urandom_range(0, 4);
            end
            else
                stream_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // receiver: result ready with per-transaction stalls and a long hold
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin : receiver
        int w;
        if (rst_n)
        begin
            if (hold_token_seen != long_hold_token)
            begin
                hold_token_seen <= long_hold_token;
                long_stall      <= LONG_HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else if (long_stall > 0)
            begin
                long_stall      <= long_stall - 1;
                result_ch.ready <= 1'b0;
            end
            else if (out_fire)
            begin
                w = receiver_steady ? 0 : $urandom_range(0, 4);
                stall_left      <= w;
                result_ch.ready <= (w == 0);
            end
            else if (stall_left > 1)
            begin
                stall_left      <= stall_left - 1;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                stall_left      <= 0;
                result_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------

    function automatic void add_bits(logic [VALUE_W-1:0] v, int n);
        for (int i = n - 1; i >= 0; i--)
            bit_buf.push_back(v[i]);
    endfunction

    function automatic void queue_byte(byte_t b);
        send_bytes.push_back(b);
        bytes_queued++;
    endfunction

    // pack pending bits into bytes, trailing bits random
    function automatic void flush_bits();
        byte_t b;
        while (bit_buf.size() > 0)
        begin
            b = byte_t'($urandom);
            for (int i = 7; i >= 0; i--)
            begin
                if (bit_buf.size() > 0)
                    b[i] = bit_buf.pop_front();
            end
            queue_byte(b);
        end
    endfunction

    // mostly narrow widths, sometimes wide
    function automatic int pick_width(int maxw);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return $urandom_range(0, (maxw < 6) ? maxw : 6);
        else if (r < 9)
            return $urandom_range(0, (maxw < 16) ? maxw : 16);
        return $urandom_range(0, maxw);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_field(int w);
        logic [VALUE_W-1:0] mask;
        logic [31:0]        r;
        if (w == 0)
            return '0;
        mask = {VALUE_W{1'b1}} >> (VALUE_W - w);
        case ($urandom_range(0, 7))
            0:       return mask;
            1:       return 31'(1) << (w - 1);
            2:       return mask >> 1;
            default:
            begin
                r = $urandom;
                return r[VALUE_W-1:0] & mask;
            end
        endcase
    endfunction

    // one well-formed record of the given kind into the bit buffer
    function automatic void random_record(kind_t k);
        int   w;
        int   terms;
        logic f;
        logic add_on;
        logic mul_on;
        if (k == KIND_RECT)
        begin
            w = pick_width(31);
            add_bits(31'(w), RECT_WIDTH_BITS);
            repeat (4) add_bits(rand_field(w), w);
        end
        else if (k == KIND_MATRIX)
        begin
            // scale and skew pairs, each behind a flag
            repeat (2)
            begin
                f = 1'($urandom_range(0, 1));
                add_bits(31'(f), 1);
                if (f)
                begin
                    w = pick_width(31);
                    add_bits(31'(w), MX_WIDTH_BITS);
                    repeat (2) add_bits(rand_field(w), w);
                end
            end
            w = pick_width(31);
            add_bits(31'(w), MX_WIDTH_BITS);
            repeat (2) add_bits(rand_field(w), w);
        end
        else
        begin
            add_on = 1'($urandom_range(0, 1));
            mul_on = 1'($urandom_range(0, 1));
            w      = $urandom_range(0, 15);
            terms  = (k == KIND_CX_ALPHA) ? 4 : 3;
            add_bits(31'(add_on), 1);
            add_bits(31'(mul_on), 1);
            add_bits(31'(w), CX_WIDTH_BITS);
            if (mul_on)
                repeat (terms) add_bits(rand_field(w), w);
            if (add_on)
                repeat (terms) add_bits(rand_field(w), w);
        end
    endfunction

    // records with random content, some noise and cut-off records
    function automatic void fill_phase(kind_t k, int nbytes);
        int start;
        int r;
        int cut;
        start = bytes_queued;
        while (bytes_queued - start < nbytes)
        begin
            r = $urandom_range(0, 19);
            if (r < 17)
                random_record(k);
            else if (r == 17)
                repeat ($urandom_range(1, 3)) add_bits(31'($urandom), 8);
            else
            begin
                random_record(k);
                if (bit_buf.size() > 1)
                begin
                    cut = $urandom_range(1, bit_buf.size() - 1);
                    repeat (cut) void'(bit_buf.pop_back());
                end
            end
            flush_bits();
        end
    endfunction

    task automatic wait_results();
        while (!(bytes_accepted == bytes_queued && expected_fields.size() == 0))
            @(negedge clk);
    endtask

    // drained and the parser given time to finish a silent byte
    task automatic wait_settled();
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_kind(kind_t k);
        wait_settled();
        @(negedge clk);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.record_kind <= k;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------

    initial
    begin : sequence_main
        kind_t phase_kinds[6];
        wait (rst_n === 1'b1);
        @(negedge clk);

        // reset kind is matrix: no scale, no skew, zero-width translate
        add_bits(31'd0, 1);
        add_bits(31'd0, 1);
        add_bits(31'd0, MX_WIDTH_BITS);
        flush_bits();
        // full-width scale at both extremes, narrow translate
        add_bits(31'd1, 1);
        add_bits(31'd31, MX_WIDTH_BITS);
        add_bits(31'h3FFFFFFF, 31);
        add_bits(31'h40000000, 31);
        add_bits(31'd0, 1);
        add_bits(31'd2, MX_WIDTH_BITS);
        add_bits(31'b10, 2);
        add_bits(31'b01, 2);
        flush_bits();

        // rectangle: one-bit fields, then zero width
        write_kind(KIND_RECT);
        add_bits(31'd1, RECT_WIDTH_BITS);
        add_bits(31'b1010, 4);
        flush_bits();
        add_bits(31'd0, RECT_WIDTH_BITS);
        flush_bits();
        // all-ones and all-zero bytes leave a record open for the kind change
        queue_byte(8'hFF);
        queue_byte(8'h00);

        // color transform: empty record, then both term sets
        write_kind(KIND_CX);
        add_bits(31'b00, 2);
        add_bits(31'b1010, CX_WIDTH_BITS);
        flush_bits();
        add_bits(31'b11, 2);
        add_bits(31'd4, CX_WIDTH_BITS);
        add_bits(31'b1000, 4);
        add_bits(31'b0111, 4);
        add_bits(31'b0000, 4);
        add_bits(31'b0001, 4);
        add_bits(31'b1111, 4);
        add_bits(31'b0010, 4);
        flush_bits();

        // color transform with alpha: zero-width add terms, then mul terms
        write_kind(KIND_CX_ALPHA);
        add_bits(31'b10, 2);
        add_bits(31'd0, CX_WIDTH_BITS);
        flush_bits();
        add_bits(31'b01, 2);
        add_bits(31'd3, CX_WIDTH_BITS);
        add_bits(31'b011, 3);
        add_bits(31'b100, 3);
        add_bits(31'b111, 3);
        add_bits(31'b000, 3);
        flush_bits();

        // random phases over all kinds
        phase_kinds[0] = KIND_RECT;
        phase_kinds[1] = KIND_CX_ALPHA;
        phase_kinds[2] = KIND_MATRIX;
        phase_kinds[3] = KIND_CX;
        phase_kinds[4] = kind_t'($urandom_range(0, 3));
        phase_kinds[5] = kind_t'($urandom_range(0, 3));
        foreach (phase_kinds[p])
        begin
            write_kind(phase_kinds[p]);
            sender_steady   = 1'b0;
            receiver_steady = 1'b0;
            if (p == 0)
            begin
                // receiver blocked while bytes keep coming
                sender_steady = 1'b1;
                long_hold_token++;
                fill_phase(phase_kinds[p], PHASE_BYTES);
            end
            else if (p == 1)
            begin
                // back-to-back on both sides
                sender_steady   = 1'b1;
                receiver_steady = 1'b1;
                fill_phase(phase_kinds[p], PHASE_BYTES);
            end
            else if (p == 3)
            begin
                // sender waits for the block to drain mid-phase
                fill_phase(phase_kinds[p], PHASE_BYTES / 2);
                wait_results();
                fill_phase(phase_kinds[p], PHASE_BYTES / 2);
            end
            else
                fill_phase(phase_kinds[p], PHASE_BYTES);
        end

        wait_settled();
        if (expected_fields.size() != 0)
        begin
            $error("%0d expected fields never arrived", expected_fields.size());
            mismatch_count++;
        end
        $display("run covered %0d bytes under %0d record kind writes", bytes_accepted,
                 kind_writes);
        $display("%0d decoded fields compared, %0d of them empty-record markers",
                 fields_checked, empty_records);
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // run limit
    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d fields outstanding", expected_fields.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[bit_packed_record_decoder.f]
+incdir+design
design/bpr_pkg.sv
design/bpr_stream_if.sv
design/bpr_result_if.sv
design/bpr_cfg_if.sv
design/bpr_ctrl.sv
design/bpr_datapath.sv
design/bit_packed_record_decoder.sv
test/testbench.sv
